// ----- rtl/core/drlt_pkg.sv -----
package drlt_pkg;

    // Layer dimensions and number formats.
    localparam int MAX_INPUTS  = 64;
    localparam int MAX_OUTPUTS = 64;
    localparam int VALUE_W     = 16;
    localparam int IN_W        = $clog2(MAX_INPUTS);
    localparam int OUT_W       = $clog2(MAX_OUTPUTS);
    localparam int WDEPTH      = MAX_INPUTS * MAX_OUTPUTS;
    localparam int WADDR_W     = $clog2(WDEPTH);
    localparam int CNT_W       = 7;
    localparam int INDEX_W     = 12;
    localparam int POS_W       = 6;
    localparam int GRAD_W      = 32;
    localparam int DG_W        = VALUE_W + 2;
    localparam int PROD_W      = GRAD_W + DG_W;
    localparam int WIDE_W      = PROD_W + 2;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [2:0] {
        CMD_WR_WEIGHT  = 3'd0,
        CMD_WR_BIAS    = 3'd1,
        CMD_PUSH_IN    = 3'd2,
        CMD_PUSH_DELTA = 3'd3,
        CMD_UPDATE     = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_FWD   = 2'd0,
        KIND_DELTA = 2'd1,
        KIND_UPD   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        MODE_FWD   = 3'd0,
        MODE_GRAD  = 3'd1,
        MODE_DELTA = 3'd2,
        MODE_UPD   = 3'd3,
        MODE_UPB   = 3'd4,
        MODE_CLR   = 3'd5
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd2;

    typedef struct packed {
        logic                 wr_weight;
        logic                 wr_bias;
        logic                 push_in;
        logic                 push_delta;
        logic [INDEX_W-1:0]   index;
        logic [CNT_W-1:0]     elem;
        logic [VALUE_W-1:0]   value;
        t_mode                mode;
        logic                 rd;
        logic                 mul;
        logic                 acc;
        logic                 first;
        logic                 active;
        logic [OUT_W-1:0]     o;
        logic [IN_W-1:0]      i;
        logic                 out_load;
        t_kind                kind;
        logic                 err;
        logic                 fin;
        logic [POS_W-1:0]     pos;
        logic [VALUE_W-1:0]   lr;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
    } t_ctl_stat;

    function automatic logic [WADDR_W-1:0] waddr_of(input logic [OUT_W-1:0] o,
                                                    input logic [IN_W-1:0] i);
        return WADDR_W'(int'(o) * MAX_INPUTS + int'(i));
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
        if (&v[WIDE_W-1:VALUE_W-1] || ~|v[WIDE_W-1:VALUE_W-1]) begin
            return v[VALUE_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VALUE_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [WIDE_W-1:0] v);
        if (&v[WIDE_W-1:GRAD_W-1] || ~|v[WIDE_W-1:GRAD_W-1]) begin
            return v[GRAD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(GRAD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(GRAD_W-1){1'b1}}};
        end
    endfunction

    // Q16.16 to Q8.8, round half up, saturate.
    function automatic logic signed [VALUE_W-1:0] to_value(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] t;
        t = v + WIDE_W'(128);
        return sat_val(t >>> 8);
    endfunction

endpackage

// ----- rtl/core/drlt_datapath.sv -----
module drlt_datapath import drlt_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl_cmd                  i_cmd,
    output t_ctl_stat                 o_stat,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_kind                     o_kind,
    output logic [POS_W-1:0]          o_pos,
    output logic [VALUE_W-1:0]        o_value,
    output logic                      o_err,
    output logic                      o_fin
);

    logic signed [VALUE_W-1:0] r_wmem  [WDEPTH];
    logic signed [GRAD_W-1:0]  r_gmem  [WDEPTH];
    logic signed [VALUE_W-1:0] r_bmem  [MAX_OUTPUTS];
    logic signed [GRAD_W-1:0]  r_bgmem [MAX_OUTPUTS];
    logic signed [VALUE_W-1:0] r_xmem  [MAX_INPUTS];
    logic signed [VALUE_W-1:0] r_amem  [MAX_OUTPUTS];
    logic signed [VALUE_W-1:0] r_dmem  [MAX_OUTPUTS];
    logic signed [DG_W-1:0]    r_gvec  [MAX_OUTPUTS];

    logic signed [VALUE_W-1:0] r_wq, r_bq, r_xq, r_aq, r_dq;
    logic signed [GRAD_W-1:0]  r_gq, r_bgq;
    logic signed [DG_W-1:0]    r_gvq;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [WIDE_W-1:0]  r_acc;

    logic                      r_out_valid;
    t_kind                     r_out_kind;
    logic [POS_W-1:0]          r_out_pos;
    logic [VALUE_W-1:0]        r_out_value;
    logic                      r_out_err;
    logic                      r_out_fin;

    logic [WADDR_W-1:0]        waddr;
    logic signed [DG_W-1:0]    g;
    logic signed [GRAD_W-1:0]  mul_a;
    logic signed [DG_W-1:0]    mul_b;
    logic signed [WIDE_W-1:0]  prod_w;
    logic signed [WIDE_W-1:0]  upd_rnd;
    logic signed [WIDE_W-1:0]  upd_d;
    logic signed [WIDE_W-1:0]  n_acc;
    logic signed [VALUE_W-1:0] act_q;
    logic signed [VALUE_W-1:0] out_val;
    logic signed [VALUE_W-1:0] lr_s;

    logic                      w_we, g_we, b_we, bg_we, a_we;
    logic [WADDR_W-1:0]        w_wa;
    logic [OUT_W-1:0]          b_wa;
    logic signed [VALUE_W-1:0] w_wd, b_wd, a_wd;
    logic signed [GRAD_W-1:0]  g_wd, bg_wd;

    assign waddr  = waddr_of(i_cmd.o, i_cmd.i);
    assign lr_s   = $signed(i_cmd.lr);
    assign g      = (r_aq > 0) ? (DG_W'(r_dq) <<< 1) : '0;
    assign prod_w = WIDE_W'(r_prod);

    always_comb begin
        unique case (i_cmd.mode)
            MODE_FWD: begin
                mul_a = GRAD_W'(r_wq);
                mul_b = DG_W'(r_xq);
            end
            MODE_GRAD: begin
                mul_a = GRAD_W'(r_xq);
                mul_b = g;
            end
            MODE_DELTA: begin
                mul_a = GRAD_W'(r_wq);
                mul_b = r_gvq;
            end
            MODE_UPD: begin
                mul_a = r_gq;
                mul_b = DG_W'(lr_s);
            end
            MODE_UPB: begin
                mul_a = r_bgq;
                mul_b = DG_W'(lr_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        upd_rnd = prod_w + WIDE_W'(32768);
        upd_d   = upd_rnd >>> 16;
        if (i_cmd.mode == MODE_FWD) begin
            n_acc = (i_cmd.first ? (WIDE_W'(r_bq) <<< 8) : r_acc) + prod_w;
        end else begin
            n_acc = (i_cmd.first ? '0 : r_acc) + prod_w;
        end
        act_q = to_value(r_acc);
        unique case (i_cmd.kind)
            KIND_FWD:   out_val = i_cmd.err ? '0 : (act_q[VALUE_W-1] ? '0 : act_q);
            KIND_DELTA: out_val = i_cmd.err ? '0 : act_q;
            default:    out_val = '0;
        endcase
    end

    // One write port per store.
    always_comb begin
        w_we = i_cmd.wr_weight || (i_cmd.acc && i_cmd.mode == MODE_UPD && i_cmd.active);
        w_wa = i_cmd.wr_weight ? i_cmd.index[WADDR_W-1:0] : waddr;
        w_wd = i_cmd.wr_weight ? $signed(i_cmd.value)
                               : sat_val(WIDE_W'(r_wq) + upd_d);

        g_we = i_cmd.acc && (i_cmd.mode == MODE_GRAD || i_cmd.mode == MODE_UPD ||
                             i_cmd.mode == MODE_CLR);
        g_wd = (i_cmd.mode == MODE_GRAD)
             ? sat_grad(WIDE_W'(r_gq) + WIDE_W'(sat_grad(prod_w))) : '0;

        b_we = i_cmd.wr_bias || (i_cmd.acc && i_cmd.mode == MODE_UPB && i_cmd.active);
        b_wa = i_cmd.wr_bias ? i_cmd.index[OUT_W-1:0] : i_cmd.o;
        b_wd = i_cmd.wr_bias ? $signed(i_cmd.value)
                             : sat_val(WIDE_W'(r_bq) + upd_d);

        bg_we = i_cmd.acc && ((i_cmd.mode == MODE_GRAD && i_cmd.first) ||
                              i_cmd.mode == MODE_UPB ||
                              (i_cmd.mode == MODE_CLR && i_cmd.first));
        bg_wd = (i_cmd.mode == MODE_GRAD)
              ? sat_grad(WIDE_W'(r_bgq) + (WIDE_W'(g) <<< 8)) : '0;

        a_we = (i_cmd.acc && i_cmd.mode == MODE_CLR && i_cmd.first) ||
               (i_cmd.out_load && i_cmd.kind == KIND_FWD);
        a_wd = i_cmd.out_load ? out_val : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_wa] <= w_wd;
        end
        if (g_we) begin
            r_gmem[waddr] <= g_wd;
        end
        if (b_we) begin
            r_bmem[b_wa] <= b_wd;
        end
        if (bg_we) begin
            r_bgmem[i_cmd.o] <= bg_wd;
        end
        if (a_we) begin
            r_amem[i_cmd.o] <= a_wd;
        end
        if (i_cmd.push_in) begin
            r_xmem[i_cmd.elem[IN_W-1:0]] <= $signed(i_cmd.value);
        end
        if (i_cmd.push_delta) begin
            r_dmem[i_cmd.elem[OUT_W-1:0]] <= $signed(i_cmd.value);
        end
        if (i_cmd.acc && i_cmd.mode == MODE_GRAD && i_cmd.first) begin
            r_gvec[i_cmd.o] <= g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_wq  <= r_wmem[waddr];
            r_gq  <= r_gmem[waddr];
            r_bq  <= r_bmem[i_cmd.o];
            r_bgq <= r_bgmem[i_cmd.o];
            r_aq  <= r_amem[i_cmd.o];
            r_dq  <= r_dmem[i_cmd.o];
            r_gvq <= r_gvec[i_cmd.o];
            r_xq  <= r_xmem[i_cmd.i];
        end
        if (i_cmd.mul) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.acc && (i_cmd.mode == MODE_FWD || i_cmd.mode == MODE_DELTA)) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind  <= i_cmd.kind;
            r_out_pos   <= i_cmd.pos;
            r_out_value <= out_val;
            r_out_err   <= i_cmd.err;
            r_out_fin   <= i_cmd.fin;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_pos   = r_out_pos;
    assign o_value = r_out_value;
    assign o_err   = r_out_err;
    assign o_fin   = r_out_fin;

endmodule

// ----- rtl/core/drlt_controller.sv -----
module drlt_controller import drlt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_command,
    input  logic [INDEX_W-1:0]    i_index,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic                  i_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [VALUE_W-1:0]    i_cfg_data,
    input  t_ctl_stat             i_stat,
    output t_ctl_cmd              o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_MUL   = 6'b001000,
        S_ACC   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    t_mode                r_mode, n_mode;
    logic [OUT_W-1:0]     r_o, n_o;
    logic [IN_W-1:0]      r_i, n_i;
    logic                 r_err, n_err;
    logic [CNT_W-1:0]     r_ec, n_ec;
    logic [CNT_W-1:0]     r_input_count, r_output_count;
    logic [VALUE_W-1:0]   r_lr;

    logic [CNT_W-1:0]     ni, no;
    logic [CNT_W:0]       count;
    logic                 accept;
    logic                 last_i, last_o, full_i, full_o;

    always_comb begin
        if (r_input_count == '0) begin
            ni = CNT_W'(1);
        end else if (r_input_count > CNT_W'(MAX_INPUTS)) begin
            ni = CNT_W'(MAX_INPUTS);
        end else begin
            ni = r_input_count;
        end
        if (r_output_count == '0) begin
            no = CNT_W'(1);
        end else if (r_output_count > CNT_W'(MAX_OUTPUTS)) begin
            no = CNT_W'(MAX_OUTPUTS);
        end else begin
            no = r_output_count;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign count       = {1'b0, r_ec} + (CNT_W+1)'(1);
    assign last_i      = (CNT_W'(r_i) == ni - CNT_W'(1));
    assign last_o      = (CNT_W'(r_o) == no - CNT_W'(1));
    assign full_i      = (r_i == IN_W'(MAX_INPUTS - 1));
    assign full_o      = (r_o == OUT_W'(MAX_OUTPUTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count  <= CNT_W'(64);
            r_output_count <= CNT_W'(64);
            r_lr           <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INPUT_COUNT:  r_input_count  <= i_cfg_data[CNT_W-1:0];
                CFG_OUTPUT_COUNT: r_output_count <= i_cfg_data[CNT_W-1:0];
                CFG_LEARN_RATE:   r_lr           <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_o     = r_o;
        n_i     = r_i;
        n_err   = r_err;
        n_ec    = r_ec;
        unique case (r_state)
            S_CLEAR: begin
                n_i = r_i + IN_W'(1);
                if (full_i) begin
                    n_i = '0;
                    n_o = r_o + OUT_W'(1);
                    if (full_o) begin
                        n_o     = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_o   = '0;
                    n_i   = '0;
                    n_err = 1'b0;
                    unique case (i_command)
                        CMD_PUSH_IN, CMD_PUSH_DELTA: begin
                            n_ec = count[CNT_W] ? {CNT_W{1'b1}} : count[CNT_W-1:0];
                            if (i_last) begin
                                n_ec = '0;
                                if (i_command == CMD_PUSH_IN) begin
                                    n_mode  = MODE_FWD;
                                    n_err   = (count != {1'b0, ni});
                                    n_state = (count != {1'b0, ni}) ? S_EMIT : S_READ;
                                end else if (count != {1'b0, no}) begin
                                    n_mode  = MODE_DELTA;
                                    n_err   = 1'b1;
                                    n_state = S_EMIT;
                                end else begin
                                    n_mode  = MODE_GRAD;
                                    n_state = S_READ;
                                end
                            end
                        end
                        CMD_UPDATE: begin
                            n_mode  = MODE_UPD;
                            n_state = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC: begin
                n_state = S_READ;
                unique case (r_mode)
                    MODE_FWD: begin
                        if (last_i) begin
                            n_state = S_EMIT;
                        end else begin
                            n_i = r_i + IN_W'(1);
                        end
                    end
                    MODE_GRAD: begin
                        if (last_i) begin
                            n_i = '0;
                            if (last_o) begin
                                n_o    = '0;
                                n_mode = MODE_DELTA;
                            end else begin
                                n_o = r_o + OUT_W'(1);
                            end
                        end else begin
                            n_i = r_i + IN_W'(1);
                        end
                    end
                    MODE_DELTA: begin
                        if (last_o) begin
                            n_state = S_EMIT;
                        end else begin
                            n_o = r_o + OUT_W'(1);
                        end
                    end
                    MODE_UPD: begin
                        if (full_i) begin
                            n_mode = MODE_UPB;
                        end else begin
                            n_i = r_i + IN_W'(1);
                        end
                    end
                    MODE_UPB: begin
                        if (full_o) begin
                            n_state = S_EMIT;
                        end else begin
                            n_o    = r_o + OUT_W'(1);
                            n_i    = '0;
                            n_mode = MODE_UPD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    unique case (r_mode)
                        MODE_FWD: begin
                            if (last_o) begin
                                n_state = S_IDLE;
                            end else begin
                                n_o     = r_o + OUT_W'(1);
                                n_i     = '0;
                                n_state = r_err ? S_EMIT : S_READ;
                            end
                        end
                        MODE_DELTA: begin
                            if (r_err || last_i) begin
                                n_state = S_IDLE;
                            end else begin
                                n_i     = r_i + IN_W'(1);
                                n_o     = '0;
                                n_state = S_READ;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode  <= MODE_CLR;
            r_o     <= '0;
            r_i     <= '0;
            r_err   <= 1'b0;
            r_ec    <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_o     <= n_o;
            r_i     <= n_i;
            r_err   <= n_err;
            r_ec    <= n_ec;
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.wr_weight  = accept && i_command == CMD_WR_WEIGHT &&
                           32'(i_index) < 32'(WDEPTH);
        o_cmd.wr_bias    = accept && i_command == CMD_WR_BIAS &&
                           32'(i_index) < 32'(MAX_OUTPUTS);
        o_cmd.push_in    = accept && i_command == CMD_PUSH_IN &&
                           32'(r_ec) < 32'(MAX_INPUTS);
        o_cmd.push_delta = accept && i_command == CMD_PUSH_DELTA &&
                           32'(r_ec) < 32'(MAX_OUTPUTS);
        o_cmd.index      = i_index;
        o_cmd.elem       = r_ec;
        o_cmd.value      = i_value;
        o_cmd.mode       = r_mode;
        o_cmd.rd         = (r_state == S_READ);
        o_cmd.mul        = (r_state == S_MUL);
        o_cmd.acc        = (r_state == S_ACC) || (r_state == S_CLEAR);
        o_cmd.first      = (r_mode == MODE_DELTA) ? (r_o == '0) : (r_i == '0);
        unique case (r_mode)
            MODE_UPD: o_cmd.active = (CNT_W'(r_o) < no) && (CNT_W'(r_i) < ni);
            MODE_UPB: o_cmd.active = (CNT_W'(r_o) < no);
            default:  o_cmd.active = 1'b1;
        endcase
        o_cmd.o          = r_o;
        o_cmd.i          = r_i;
        o_cmd.out_load   = (r_state == S_EMIT) && i_stat.out_free;
        o_cmd.err        = r_err;
        o_cmd.lr         = r_lr;
        unique case (r_mode)
            MODE_FWD: begin
                o_cmd.kind = KIND_FWD;
                o_cmd.pos  = POS_W'(r_o);
                o_cmd.fin  = last_o;
            end
            MODE_DELTA: begin
                o_cmd.kind = KIND_DELTA;
                o_cmd.pos  = r_err ? '0 : POS_W'(r_i);
                o_cmd.fin  = r_err || last_i;
            end
            default: begin
                o_cmd.kind = KIND_UPD;
                o_cmd.pos  = '0;
                o_cmd.fin  = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/core/dense_relu_layer_trainer.sv -----
// A forward pass runs read, multiply and accumulate steps over the inputs of each output
// neuron after the last input transfer, then emits its result; a backward pass first
// accumulates the gradient of every active weight, then emits the delta of each input;
// an update walks the whole weight and bias store. Writes and non-final pushes start no
// loop; all passes share one multiply-accumulate. Reset is synchronous and active low;
// afterwards a clearing pass zeroes the gradient and activation stores and takes no input.
module dense_relu_layer_trainer import drlt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [31:0]           i_s_tdata,  // command[2:0], index[14:3], value[30:15]
    input  logic                  i_s_tlast,
    // Result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [23:0]           o_m_tdata,  // position[5:0], result_value[21:6],
                                              // length_error[22]
    output logic                  o_m_tlast,
    output logic [1:0]            o_m_tuser,  // kind[1:0]
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [VALUE_W-1:0]    i_cfg_data
);

    // The controller sequences every loop of the layer; the datapath holds all of the
    // stores, the shared multiplier, the accumulator and the result register.
    t_ctl_cmd           w_cmd;
    t_ctl_stat          w_stat;
    t_kind              w_kind;
    logic [POS_W-1:0]   w_pos;
    logic [VALUE_W-1:0] w_value;
    logic               w_err;

    drlt_controller u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_command   (i_s_tdata[2:0]),
        .i_index     (i_s_tdata[14:3]),
        .i_value     (i_s_tdata[30:15]),
        .i_last      (i_s_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    drlt_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_kind  (w_kind),
        .o_pos   (w_pos),
        .o_value (w_value),
        .o_err   (w_err),
        .o_fin   (o_m_tlast)
    );

    // The result transfer carries the kind in tuser and the run end in tlast.
    assign o_m_tdata = {1'b0, w_err, w_value, w_pos};
    assign o_m_tuser = w_kind;

`ifndef SYNTHESIS
    // A result is only loaded when the output register is free or being emptied.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("result loaded over a pending transfer");

    // No loop step runs while an input transfer can be taken.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !(w_cmd.rd || w_cmd.mul || w_cmd.acc))
        else $error("datapath step while accepting input");

    // An update completion is always the only and last result of its run.
    a_upd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_UPD) |-> o_m_tlast)
        else $error("update result without final mark");
`endif

endmodule

// ----- dv/tb_dense_relu_layer_trainer.sv -----
module tb_dense_relu_layer_trainer;
    timeunit 1ns;
    timeprecision 1ps;

    import drlt_pkg::*;

    // Command codes that the block leaves unused; they must change nothing.
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // Generous cycle budget: several times the slowest legal run, counting
    // every item as a full update pass, plus the clearing pass after reset.
    localparam int CYCLE_LIMIT = 20000000;

    // Largest layer whose stores are read after the initial load, in both dimensions.
    localparam int INIT_DIM = 4;

    // One result as the block reports it.
    typedef struct packed {
        t_kind        kind;
        logic [5:0]   pos;
        logic [15:0]  value;
        logic         err;
        logic         fin;
    } layer_result_t;

    // One row of the directed stimulus. Where known_res is set, the single
    // result of the row is typed in here rather than taken from the predictor.
    typedef struct packed {
        logic [2:0]     cmd;
        logic [11:0]    idx;
        logic [15:0]    val;
        logic           is_last;
        logic           known_res;
        layer_result_t  res;
    } stim_row_t;

    localparam int N_ROWS = 23;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic i_s_tlast = 1'b0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic o_m_tlast;
    logic [1:0] o_m_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [VALUE_W-1:0] i_cfg_data = '0;

    dense_relu_layer_trainer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the layer: parameters, gradients, vectors, counter
    // and the three configuration registers.
    // ------------------------------------------------------------------
    int          shadow_w[WDEPTH];
    int          shadow_b[MAX_OUTPUTS];
    int          shadow_wgrad[WDEPTH];
    int          shadow_bgrad[MAX_OUTPUTS];
    int          shadow_x[MAX_INPUTS];
    int          shadow_act[MAX_OUTPUTS];
    int          shadow_delta[MAX_OUTPUTS];
    int unsigned shadow_elem;
    logic [6:0]  reg_in_count = 7'd64;
    logic [6:0]  reg_out_count = 7'd64;
    int          reg_rate = 0;

    // Results still owed by the block, oldest first.
    layer_result_t pending_results[$];

    int  failures = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;

    function automatic longint sat16(input longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic longint sat32(input longint v);
        return (v > 64'sd2147483647) ? 64'sd2147483647 :
               ((v < -64'sd2147483648) ? -64'sd2147483648 : v);
    endfunction

    // Q16.16 to Q8.8 with round half up and saturation.
    function automatic int q16_to_q8(input longint v);
        return int'(sat16((v + 128) >>> 8));
    endfunction

    function automatic int active_count(input logic [6:0] raw);
        return (raw == 0) ? 1 : ((raw > 64) ? 64 : int'(raw));
    endfunction

    function automatic void owe(input t_kind k, input int p, input int v,
                                input bit e, input bit f);
        layer_result_t r;
        r.kind = k;
        r.pos = 6'(p);
        r.value = 16'(v);
        r.err = e;
        r.fin = f;
        pending_results.push_back(r);
    endfunction

    // Predict what one accepted input transfer does to the layer and which
    // results it causes.
    function automatic void layer_step(input logic [2:0] cmd, input logic [11:0] idx,
                                       input logic [15:0] raw_val, input bit is_last);
        int     val;
        int     ni;
        int     no;
        int     cnt;
        int     a;
        bit     ok;
        longint acc;
        longint d;
        longint g[MAX_OUTPUTS];
        val = int'($signed(raw_val));
        ni = active_count(reg_in_count);
        no = active_count(reg_out_count);
        if (cmd == CMD_WR_WEIGHT) begin
            shadow_w[idx] = val;
        end else if (cmd == CMD_WR_BIAS) begin
            if (idx < MAX_OUTPUTS) shadow_b[idx] = val;
        end else if (cmd == CMD_PUSH_IN || cmd == CMD_PUSH_DELTA) begin
            if (cmd == CMD_PUSH_IN && shadow_elem < MAX_INPUTS) shadow_x[shadow_elem] = val;
            if (cmd == CMD_PUSH_DELTA && shadow_elem < MAX_OUTPUTS)
                shadow_delta[shadow_elem] = val;
            cnt = shadow_elem + 1;
            shadow_elem = (cnt > 127) ? 127 : cnt;
            if (is_last) begin
                shadow_elem = 0;
                if (cmd == CMD_PUSH_IN) begin
                    // Forward pass; a wrong element count forces zeros and flags it.
                    ok = (cnt == ni);
                    for (int o = 0; o < no; o++) begin
                        a = 0;
                        if (ok) begin
                            acc = longint'(shadow_b[o]) * 256;
                            for (int i = 0; i < ni; i++)
                                acc += longint'(shadow_w[o * MAX_INPUTS + i]) * shadow_x[i];
                            a = q16_to_q8(acc);
                            if (a < 0) a = 0;
                        end
                        shadow_act[o] = a;
                        owe(KIND_FWD, o, a, !ok, o + 1 == no);
                    end
                end else if (cnt != no) begin
                    owe(KIND_DELTA, 0, 0, 1'b1, 1'b1);
                end else begin
                    // Backward pass: gate by the ReLU slope, doubled.
                    for (int o = 0; o < no; o++) begin
                        g[o] = (shadow_act[o] > 0) ? 2 * longint'(shadow_delta[o]) : 0;
                        shadow_bgrad[o] = int'(sat32(longint'(shadow_bgrad[o]) +
                                                     sat32(g[o] * 256)));
                        for (int i = 0; i < ni; i++)
                            shadow_wgrad[o * MAX_INPUTS + i] =
                                int'(sat32(longint'(shadow_wgrad[o * MAX_INPUTS + i]) +
                                           sat32(longint'(shadow_x[i]) * g[o])));
                    end
                    for (int i = 0; i < ni; i++) begin
                        acc = 0;
                        for (int o = 0; o < no; o++)
                            acc += longint'(shadow_w[o * MAX_INPUTS + i]) * g[o];
                        owe(KIND_DELTA, i, q16_to_q8(acc), 1'b0, i + 1 == ni);
                    end
                end
            end
        end else if (cmd == CMD_UPDATE) begin
            for (int o = 0; o < no; o++) begin
                for (int i = 0; i < ni; i++) begin
                    d = (longint'(reg_rate) * shadow_wgrad[o * MAX_INPUTS + i] + 32768) >>> 16;
                    shadow_w[o * MAX_INPUTS + i] =
                        int'(sat16(longint'(shadow_w[o * MAX_INPUTS + i]) + d));
                end
                d = (longint'(reg_rate) * shadow_bgrad[o] + 32768) >>> 16;
                shadow_b[o] = int'(sat16(longint'(shadow_b[o]) + d));
            end
            for (int w = 0; w < WDEPTH; w++) shadow_wgrad[w] = 0;
            for (int o = 0; o < MAX_OUTPUTS; o++) shadow_bgrad[o] = 0;
            owe(KIND_UPD, 0, 0, 1'b0, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the scoreboard.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_m_tready <= no_idle || ($urandom_range(99) >= 32);
    end

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        layer_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result transfer, actual data %0h kind %0h",
                         $time, o_m_tdata, o_m_tuser);
                failures++;
            end else begin
                want = pending_results.pop_front();
                compare_field("kind", want.kind, o_m_tuser);
                compare_field("position", want.pos, o_m_tdata[5:0]);
                compare_field("result_value", want.value, o_m_tdata[21:6]);
                compare_field("length_error", want.err, o_m_tdata[22]);
                compare_field("pad bit", 0, o_m_tdata[23]);
                compare_field("final flag", want.fin, o_m_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------
    int items_sent = 0;

    // Drive one input transfer, with a random gap before it, and feed the
    // predictor once the block has taken it.
    task automatic send_item(input logic [2:0] cmd, input logic [11:0] idx,
                             input logic [15:0] val, input bit is_last);
        while (!no_idle && $urandom_range(99) < 32) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {1'b0, val, idx, cmd};
        i_s_tlast <= is_last;
        do @(posedge i_clk); while (!o_s_tready);
        layer_step(cmd, idx, val, is_last);
        items_sent++;
    endtask

    // Wait until every result is in, then give a write or a partial push
    // time to settle before a register changes.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] ridx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ridx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (ridx)
            CFG_INPUT_COUNT:  reg_in_count = data[6:0];
            CFG_OUTPUT_COUNT: reg_out_count = data[6:0];
            CFG_LEARN_RATE:   reg_rate = int'($signed(data));
            default: ;
        endcase
    endtask

    // Mostly modest values so that sums do not all saturate; sometimes any value.
    function automatic logic [15:0] rand_value();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(1023)) - 512);
    endfunction

    task automatic push_vector(input logic [2:0] cmd, input int len);
        for (int k = 0; k < len; k++) send_item(cmd, 12'($urandom), rand_value(), k == len - 1);
    endtask

    // One random sequence: mostly well-formed vectors, some parameter writes,
    // a few updates, and a share of broken or meaningless traffic.
    task automatic random_sequence();
        int ni;
        int no;
        int r;
        int len;
        ni = active_count(reg_in_count);
        no = active_count(reg_out_count);
        r = $urandom_range(99);
        if (r < 40) begin
            push_vector(CMD_PUSH_IN, ni);
        end else if (r < 68) begin
            push_vector(CMD_PUSH_DELTA, no);
        end else if (r < 80) begin
            if ($urandom_range(1) == 0)
                send_item(CMD_WR_WEIGHT,
                          12'($urandom_range(no - 1) * MAX_INPUTS + $urandom_range(ni - 1)),
                          rand_value(), 1'($urandom));
            else
                send_item(CMD_WR_BIAS, ($urandom_range(3) == 0) ? 12'($urandom) :
                          12'($urandom_range(no - 1)), rand_value(), 1'($urandom));
        end else if (r < 84) begin
            send_item(CMD_UPDATE, 12'($urandom), 16'($urandom), 1'($urandom));
        end else if (r < 92) begin
            // Vector one element too short or too long.
            len = ($urandom_range(1) == 0) ? ni : no;
            len = ($urandom_range(1) == 0 && len > 1) ? len - 1 : len + 1;
            push_vector(($urandom_range(1) == 0) ? CMD_PUSH_IN : CMD_PUSH_DELTA, len);
        end else if (r < 96) begin
            // Inputs and deltas interleaved on the shared element counter.
            len = $urandom_range(ni + 1, 1);
            for (int k = 0; k < len; k++)
                send_item(($urandom_range(1) == 0) ? CMD_PUSH_IN : CMD_PUSH_DELTA,
                          12'($urandom), rand_value(), k == len - 1);
        end else begin
            send_item(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), 12'($urandom),
                      16'($urandom), 1'($urandom));
        end
    endtask

    stim_row_t dir_rows[N_ROWS] = '{
        '{CMD_WR_WEIGHT,  12'd0,    16'h8000, 1'b0, 1'b0, '0},
        '{CMD_WR_WEIGHT,  12'd4095, 16'h7fff, 1'b0, 1'b0, '0},
        '{CMD_WR_WEIGHT,  12'd1,    16'h0100, 1'b1, 1'b0, '0},
        '{CMD_WR_BIAS,    12'd0,    16'h7fff, 1'b0, 1'b0, '0},
        '{CMD_WR_BIAS,    12'd64,   16'h1234, 1'b0, 1'b0, '0},
        '{CMD_WR_BIAS,    12'd4095, 16'hffff, 1'b1, 1'b0, '0},
        '{CMD_PUSH_IN,    12'd0,    16'h7fff, 1'b0, 1'b0, '0},
        '{CMD_PUSH_IN,    12'd0,    16'h8000, 1'b1, 1'b0, '0},
        '{CMD_PUSH_IN,    12'd0,    16'h0100, 1'b1, 1'b0, '0},
        '{CMD_PUSH_DELTA, 12'd0,    16'h0100, 1'b0, 1'b0, '0},
        '{CMD_PUSH_DELTA, 12'd0,    16'hffff, 1'b1, 1'b1,
          '{KIND_DELTA, 6'd0, 16'd0, 1'b1, 1'b1}},
        '{CMD_PUSH_IN,    12'd0,    16'h0200, 1'b0, 1'b0, '0},
        '{CMD_PUSH_IN,    12'd0,    16'h0080, 1'b1, 1'b0, '0},
        '{CMD_PUSH_DELTA, 12'd0,    16'h7fff, 1'b0, 1'b0, '0},
        '{CMD_PUSH_DELTA, 12'd0,    16'h8000, 1'b0, 1'b0, '0},
        '{CMD_PUSH_DELTA, 12'd0,    16'h0100, 1'b1, 1'b0, '0},
        '{CMD_UPDATE,     12'd0,    16'h0000, 1'b0, 1'b1,
          '{KIND_UPD, 6'd0, 16'd0, 1'b0, 1'b1}},
        '{CMD_SPARE_LO,   12'hfff,  16'hffff, 1'b1, 1'b0, '0},
        '{CMD_SPARE_HI,   12'd0,    16'h0000, 1'b0, 1'b0, '0},
        '{CMD_PUSH_IN,    12'd0,    16'h0100, 1'b0, 1'b0, '0},
        '{CMD_PUSH_DELTA, 12'd0,    16'h0300, 1'b0, 1'b0, '0},
        '{CMD_PUSH_IN,    12'd0,    16'h0100, 1'b1, 1'b0, '0},
        '{CMD_PUSH_DELTA, 12'd0,    16'h0400, 1'b1, 1'b1,
          '{KIND_DELTA, 6'd0, 16'd0, 1'b1, 1'b1}}
    };

    // Register settings per random phase: raw counts (zero and values whose
    // upper bits fall away included) and the learning rate. No phase goes
    // beyond the layer loaded at the start.
    logic [15:0] phase_in[7]   = '{16'h0003, 16'hff81, 16'h0004, 16'h0001, 16'h0000,
                                   16'h0002, 16'h0004};
    logic [15:0] phase_out[7]  = '{16'h0004, 16'h0001, 16'h0001, 16'h0004, 16'hff82,
                                   16'h0003, 16'h0004};
    logic [15:0] phase_rate[7] = '{16'h7fff, 16'h8000, 16'h0100, 16'hff00, 16'h0000,
                                   16'h0040, 16'hffc0};

    initial begin
        int budget;
        shadow_elem = 0;
        for (int w = 0; w < WDEPTH; w++) begin
            shadow_w[w] = 0;
            shadow_wgrad[w] = 0;
        end
        for (int k = 0; k < MAX_OUTPUTS; k++) begin
            shadow_b[k] = 0;
            shadow_bgrad[k] = 0;
            shadow_act[k] = 0;
            shadow_delta[k] = 0;
            shadow_x[k] = 0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load every parameter and both vectors over the largest layer used
        // below, so that no later read can land on an entry that was never
        // written. This also runs a forward and a backward pass.
        write_reg(CFG_INPUT_COUNT, 16'(INIT_DIM));
        write_reg(CFG_OUTPUT_COUNT, 16'(INIT_DIM));
        no_idle = 1'b1;
        for (int o = 0; o < INIT_DIM; o++) begin
            for (int i = 0; i < INIT_DIM; i++)
                send_item(CMD_WR_WEIGHT, 12'(o * MAX_INPUTS + i), rand_value(), 1'b0);
            send_item(CMD_WR_BIAS, 12'(o), rand_value(), 1'b0);
        end
        no_idle = 1'b0;
        push_vector(CMD_PUSH_IN, INIT_DIM);
        push_vector(CMD_PUSH_DELTA, INIT_DIM);
        drain();

        // Directed rows on a small 2-by-3 layer with a unit learning rate.
        write_reg(CFG_INPUT_COUNT, 16'd2);
        write_reg(CFG_OUTPUT_COUNT, 16'd3);
        write_reg(CFG_LEARN_RATE, 16'h0100);
        for (int k = 0; k < N_ROWS; k++) begin
            send_item(dir_rows[k].cmd, dir_rows[k].idx, dir_rows[k].val, dir_rows[k].is_last);
            if (dir_rows[k].known_res) begin
                void'(pending_results.pop_back());
                pending_results.push_back(dir_rows[k].res);
            end
        end
        drain();

        // An output count above the maximum acts as the maximum; a forward
        // pass with a wrong input count shows it without reading any weight.
        write_reg(CFG_INPUT_COUNT, 16'h0001);
        write_reg(CFG_OUTPUT_COUNT, 16'h00ff);
        send_item(CMD_PUSH_IN, 12'd0, 16'h0100, 1'b0);
        send_item(CMD_PUSH_IN, 12'd0, 16'h0100, 1'b1);
        drain();

        // Random phases, one register setting each. The third runs with no
        // idling on either side.
        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_INPUT_COUNT, phase_in[p]);
            write_reg(CFG_OUTPUT_COUNT, phase_out[p]);
            write_reg(CFG_LEARN_RATE, (p == 6) ? 16'($urandom) : phase_rate[p]);
            no_idle = (p == 2);
            if (p == 0) begin
                // Run the shared element counter into saturation.
                for (int k = 0; k < 130; k++)
                    send_item(CMD_PUSH_IN, 12'($urandom), rand_value(), k == 129);
            end
            budget = items_sent + 12;
            while (items_sent < budget) random_sequence();
            drain();
        end
        no_idle = 1'b0;

        repeat (50) @(posedge i_clk);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/drlt_pkg.sv
rtl/core/drlt_datapath.sv
rtl/core/drlt_controller.sv
rtl/core/dense_relu_layer_trainer.sv
dv/tb_dense_relu_layer_trainer.sv
